[src/camera_blob_report_parser_macros.svh]
// Assertion macros for the camera report parser RTL.
`ifndef CAMERA_BLOB_REPORT_PARSER_MACROS_SVH
`define CAMERA_BLOB_REPORT_PARSER_MACROS_SVH

// Checked on every rising edge of clk_i, disabled while rst_ni is low.
`define CBRP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: antecedent in a cycle, consequent checked in the next cycle.
`define CBRP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cbrp_pkg.sv]
// Types, constants and helper functions for the camera report parser.
`timescale 1ns / 1ps
package cbrp_pkg;

  localparam int MAX_LINE   = 32;
  localparam int NUM_FIELDS = 5;

  localparam int KEPT_W  = 6;
  localparam int FIELD_W = 3;
  localparam int VAL_W   = 16;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_G     = 8'h67;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h74;

  localparam logic [BYTE_W-1:0] END_CHAR_RESET = CH_CR;

  typedef struct packed {
    logic [KEPT_W-1:0]                 kept_count;
    logic [BYTE_W-1:0]                 first_byte;
    logic [FIELD_W-1:0]                field_number;
    logic [VAL_W-1:0]                  digit_accum;
    logic                              collecting;
    logic                              fields_done;
    logic [NUM_FIELDS-1:0][VAL_W-1:0]  field_values;
    logic                              error_flag;
  } line_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] report_type;
    logic [VAL_W-1:0]  left_x;
    logic [VAL_W-1:0]  top_y;
    logic [VAL_W-1:0]  right_x;
    logic [VAL_W-1:0]  bottom_y;
    logic [BYTE_W-1:0] object_id;
    logic              error_seen;
    logic              cut_short;
  } report_t;

  // Clears everything that belongs to the current line; the error flag survives.
  function automatic line_state_t new_line(line_state_t s);
    line_state_t r;
    r = '0;
    r.error_flag = s.error_flag;
    return r;
  endfunction

  // Stores an open field's accumulator into its slot and closes the field.
  function automatic line_state_t close_field(line_state_t s);
    line_state_t r;
    r = s;
    if (s.collecting) begin
      for (int j = 0; j < NUM_FIELDS; j++) begin
        if (s.field_number == FIELD_W'(j + 1)) begin
          r.field_values[j] = s.digit_accum;
        end
      end
      if (s.field_number >= FIELD_W'(NUM_FIELDS)) begin
        r.fields_done = 1'b1;
      end
      r.collecting = 1'b0;
    end
    return r;
  endfunction

endpackage

[src/cbrp_step.sv]
// Next-state and report logic for one received byte.
`timescale 1ns / 1ps
module cbrp_step (
  input  cbrp_pkg::line_state_t state_i,
  input  logic [7:0]            rx_byte_i,
  input  logic                  line_error_i,
  input  logic [7:0]            end_char_i,
  output cbrp_pkg::line_state_t state_o,
  output logic                  emit_o,
  output cbrp_pkg::report_t     report_o
);
  import cbrp_pkg::*;

  logic        is_digit;
  logic        is_kept;
  logic [3:0]  digit;
  logic [BYTE_W-1:0] digit_full;
  line_state_t s;
  line_state_t closed;
  logic        emit;
  logic        cut;

  assign digit_full = rx_byte_i - CH_ZERO;
  assign digit      = digit_full[3:0];
  assign is_digit   = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);
  assign is_kept    = is_digit || (rx_byte_i == CH_G) || (rx_byte_i == CH_T) ||
                      (rx_byte_i == CH_SPACE) || (rx_byte_i == CH_CR) ||
                      (rx_byte_i == CH_LF);

  always_comb begin
    s    = state_i;
    emit = 1'b0;
    cut  = 1'b0;
    // a line error throws away the partial line, the byte starts a new one
    if (line_error_i) begin
      s = new_line(s);
      s.error_flag = 1'b1;
    end
    if (is_kept) begin
      if (s.kept_count == '0) begin
        s.first_byte = rx_byte_i;
      end
      if (rx_byte_i == end_char_i) begin
        emit = 1'b1;
      end else begin
        if (s.collecting && is_digit) begin
          // accum * 10 + digit, wrapping at 16 bits
          s.digit_accum = (s.digit_accum << 3) + (s.digit_accum << 1) +
                          {{(VAL_W-4){1'b0}}, digit};
        end else begin
          s = close_field(s);
          if ((rx_byte_i == CH_SPACE) && !s.fields_done &&
              (s.field_number < FIELD_W'(NUM_FIELDS))) begin
            s.field_number = s.field_number + FIELD_W'(1);
            s.digit_accum  = '0;
            s.collecting   = 1'b1;
          end
        end
        s.kept_count = s.kept_count + KEPT_W'(1);
        if (s.kept_count >= KEPT_W'(MAX_LINE)) begin
          emit = 1'b1;
          cut  = 1'b1;
        end
      end
    end
    closed = close_field(s);
    report_o.report_type = closed.first_byte;
    report_o.left_x      = closed.field_values[0];
    report_o.top_y       = closed.field_values[1];
    report_o.right_x     = closed.field_values[2];
    report_o.bottom_y    = closed.field_values[3];
    report_o.object_id   = closed.field_values[4][BYTE_W-1:0];
    report_o.error_seen  = closed.error_flag;
    report_o.cut_short   = cut;
    if (emit) begin
      s = new_line(closed);
      s.error_flag = 1'b0;
    end
    state_o = s;
    emit_o  = emit;
  end

endmodule

[src/camera_blob_report_parser.sv]
// Top level of the camera report parser: handshakes, line state and result register.
`timescale 1ns / 1ps
// Takes one received byte per item: the line state is updated by
// combinational logic at each accepted byte, so bytes can enter back
// to back. A finished report is registered at the edge that accepts the byte
// ending its line and is offered on the master side from the next cycle. While
// a report waits there with m_axis_tready low, s_axis_tready is low too, so the
// input stalls until the report is taken; with the receiver ready, a report
// leaves and the next byte enters in the same cycle. Lines end at end_char or
// after MAX_LINE kept bytes (cut_short set).
// No clearing pass after reset.
`include "camera_blob_report_parser_macros.svh"
module camera_blob_report_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,          // end_char
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,         // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,         // [0] line_error
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] report_type, [23:8] left_x, [39:24] top_y, [55:40] right_x,
  // [71:56] bottom_y, [79:72] object_id
  output logic [79:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser          // [0] error_seen, [1] cut_short
);
  import cbrp_pkg::*;

  logic [BYTE_W-1:0] end_char_q;
  line_state_t       st_q;
  line_state_t       st_d;
  logic              emit;
  report_t           report_d;
  report_t           report_q;
  logic              out_valid_q;
  logic              accept;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbrp_step u_step (
    .state_i      (st_q),
    .rx_byte_i    (s_axis_tdata),
    .line_error_i (s_axis_tuser[0]),
    .end_char_i   (end_char_q),
    .state_o      (st_d),
    .emit_o       (emit),
    .report_o     (report_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_char_q  <= END_CHAR_RESET;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        end_char_q <= cfg_wdata_i;
      end
      if (accept) begin
        st_q <= st_d;
      end
      if (accept && emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      report_q <= report_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {report_q.object_id, report_q.bottom_y, report_q.right_x,
                          report_q.top_y, report_q.left_x, report_q.report_type};
  assign m_axis_tuser  = {report_q.cut_short, report_q.error_seen};

  `CBRP_ASSERT(a_kept_below_limit, st_q.kept_count < KEPT_W'(MAX_LINE),
               "kept byte count reached the line limit without a report")
  `CBRP_ASSERT(a_field_range, st_q.field_number <= FIELD_W'(NUM_FIELDS),
               "field number beyond the last field")
  `CBRP_ASSERT(a_collect_open, !st_q.collecting || (st_q.field_number != '0),
               "collecting digits with no field open")
  `CBRP_ASSERT_NEXT(a_report_clears, accept && emit,
                    !st_q.error_flag && (st_q.kept_count == '0),
                    "line state not restarted after a report")

endmodule

[verif/camera_blob_report_parser_tb.sv]
// Self-checking testbench for the camera report line parser.
`timescale 1ns / 1ps
module testbench;
  import cbrp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_wdata_i   = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] rx_byte
  logic [0:0]  s_axis_tuser  = 1'b0;   // [0] line_error
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] report_type, [23:8] left_x, [39:24] top_y, [55:40] right_x,
  // [71:56] bottom_y, [79:72] object_id
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;           // [0] error_seen, [1] cut_short

  camera_blob_report_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the parser's line state
  logic [7:0]  term_char = END_CHAR_RESET;
  logic [5:0]  line_kept;
  logic [7:0]  line_type;
  logic [2:0]  field_idx;
  logic [15:0] digit_sum;
  logic        in_field;
  logic        fields_full;
  logic [15:0] field_val [NUM_FIELDS];
  logic        err_since_report = 1'b0;

  report_t report_queue [$];
  int      fail_count  = 0;
  int      item_count  = 0;
  int      cycle_count = 0;
  bit      tx_gaps_on  = 1'b1;
  bit      rx_stalls_on = 1'b1;
  int      rx_stall    = 0;
  int      hold_left   = 0;

  function automatic void start_line();
    line_kept   = '0;
    line_type   = '0;
    field_idx   = '0;
    digit_sum   = '0;
    in_field    = 1'b0;
    fields_full = 1'b0;
    for (int j = 0; j < NUM_FIELDS; j++) field_val[j] = '0;
  endfunction

  function automatic bit byte_is_kept(logic [7:0] b);
    return b == CH_G || b == CH_T || (b >= CH_ZERO && b <= CH_NINE) ||
           b == CH_SPACE || b == CH_CR || b == CH_LF;
  endfunction

  function automatic void close_current_field();
    if (in_field) begin
      if (field_idx >= 1 && field_idx <= NUM_FIELDS) field_val[field_idx - 1] = digit_sum;
      if (field_idx >= NUM_FIELDS) fields_full = 1'b1;
      in_field = 1'b0;
    end
  endfunction

  function automatic report_t emit_report(bit cut);
    report_t r;
    close_current_field();
    r.report_type = line_type;
    r.left_x      = field_val[0];
    r.top_y       = field_val[1];
    r.right_x     = field_val[2];
    r.bottom_y    = field_val[3];
    r.object_id   = field_val[4][7:0];
    r.error_seen  = err_since_report;
    r.cut_short   = cut;
    err_since_report = 1'b0;
    start_line();
    return r;
  endfunction

  // Advances the shadow state by one byte; returns 1 when a report is due.
  function automatic bit predict_byte(input logic [7:0] b, input logic err,
                                      output report_t rpt);
    if (err) begin
      err_since_report = 1'b1;
      start_line();
    end
    if (!byte_is_kept(b)) return 1'b0;
    if (line_kept == 0) line_type = b;
    if (b == term_char) begin
      rpt = emit_report(1'b0);
      return 1'b1;
    end
    if (in_field && b >= CH_ZERO && b <= CH_NINE) begin
      digit_sum = 16'(digit_sum * 10 + (b - CH_ZERO));
    end else begin
      close_current_field();
      if (b == CH_SPACE && !fields_full && field_idx < NUM_FIELDS) begin
        field_idx = field_idx + 3'd1;
        digit_sum = '0;
        in_field  = 1'b1;
      end
    end
    line_kept = line_kept + 6'd1;
    if (line_kept >= MAX_LINE) begin
      rpt = emit_report(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker and receiver stall draw
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (report_queue.size() == 0) begin
        $error("report with none expected: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = report_queue.pop_front();
        check_field("report_type", want.report_type, m_axis_tdata[7:0]);
        check_field("left_x",      want.left_x,      m_axis_tdata[23:8]);
        check_field("top_y",       want.top_y,       m_axis_tdata[39:24]);
        check_field("right_x",     want.right_x,     m_axis_tdata[55:40]);
        check_field("bottom_y",    want.bottom_y,    m_axis_tdata[71:56]);
        check_field("object_id",   want.object_id,   m_axis_tdata[79:72]);
        check_field("error_seen",  want.error_seen,  m_axis_tuser[0]);
        check_field("cut_short",   want.cut_short,   m_axis_tuser[1]);
      end
      rx_stall = rx_stalls_on ? $urandom_range(0, 9) : 0;
    end
  end

  // Receiver: long hold first, then the per-item stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[camera_blob_report_parser] ERROR");
      $finish;
    end
  end

  // Called and returns at a falling edge; tvalid stays up for a gapless next item.
  task automatic send_byte(input logic [7:0] b, input logic err);
    int gap;
    report_t rpt;
    gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tuser  <= err;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_byte(b, err, rpt)) report_queue.push_back(rpt);
    if (err || byte_is_kept(b)) item_count++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]), 1'b0);
  endtask

  // Random noise bytes and line errors sprinkled into otherwise clean lines
  task automatic send_line_byte(input logic [7:0] b);
    if ($urandom_range(0, 39) == 0) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(b, $urandom_range(0, 49) == 0);
  endtask

  task automatic wait_reports_drained();
    s_axis_tvalid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_end_char(input logic [7:0] v);
    wait_reports_drained();
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    term_char = v;
  endtask

  task automatic send_random_line();
    string digits;
    int nfields;
    int v;
    tx_gaps_on   = $urandom_range(0, 3) != 0;
    rx_stalls_on = $urandom_range(0, 3) != 0;
    case ($urandom_range(0, 4))
      0:       send_line_byte(CH_T);
      1, 2:    send_line_byte(CH_G);
      3:       send_line_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
      default: send_line_byte(8'($urandom_range(0, 255)));
    endcase
    nfields = $urandom_range(0, 7);
    for (int f = 0; f < nfields; f++) begin
      send_line_byte(CH_SPACE);
      if ($urandom_range(0, 9) != 0) begin
        case ($urandom_range(0, 5))
          0:       v = 0;
          1:       v = 65535;
          2:       v = 255;
          3:       v = $urandom_range(0, 9999999);
          default: v = $urandom_range(0, 999);
        endcase
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) send_line_byte(8'(digits[i]));
      end
    end
    if ($urandom_range(0, 6) != 0) send_line_byte(term_char);
    if ($urandom_range(0, 19) == 0) wait_reports_drained();
  endtask

  task automatic test_directed_lines();
    send_byte(CH_CR, 1'b0);                      // terminator as the first kept byte
    send_text(" 7");                             // leading space opens field one
    send_byte(term_char, 1'b0);
    send_text("g 99999 1 2 3 999 4");            // wrap, id truncation, extra field
    send_byte(term_char, 1'b0);
    send_text("t 5x6");                          // dropped byte inside a number
    send_byte(CH_G, 1'b1);                       // line error restarts with this byte
    send_text("  3 12");                         // empty first field
    send_byte(term_char, 1'b0);
  endtask

  task automatic test_terminator_settings();
    set_end_char(8'h00);                         // never kept: only the length limit ends
    send_byte(CH_G, 1'b0);
    repeat (20) send_text(" 9");
    repeat (40) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
    set_end_char(8'hFF);
    send_text("t 12");
    repeat (3) send_byte(8'hFF, 1'b0);
    repeat (30) send_text("1");
    set_end_char(CH_LF);                         // CR becomes content
    send_text("g 4");
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(CH_LF, 1'b0);
  endtask

  task automatic test_output_backpressure();
    set_end_char(CH_CR);
    tx_gaps_on = 1'b0;
    @(posedge clk_i);
    hold_left = 300;
    @(negedge clk_i);
    repeat (30) begin
      send_text("g 1");
      send_byte(term_char, 1'b0);
    end
    wait_reports_drained();                      // sender pauses until all reports are out
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_lines(input logic [7:0] term, input int n_items);
    int target;
    set_end_char(term);
    target = item_count + n_items;
    while (item_count < target) send_random_line();
  endtask

  initial begin
    start_line();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_lines();
    test_terminator_settings();
    test_output_backpressure();
    test_random_lines(CH_CR, 450);
    test_random_lines(CH_LF, 150);
    test_random_lines(8'h00, 120);
    test_random_lines(CH_SPACE, 80);
    test_random_lines(8'h37, 80);
    test_random_lines(8'hFF, 120);
    s_axis_tvalid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[camera_blob_report_parser] OK");
    end else begin
      $display("[camera_blob_report_parser] ERROR");
    end
    $finish;
  end

endmodule

[camera_blob_report_parser.f]
+incdir+src
src/cbrp_pkg.sv
src/cbrp_step.sv
src/camera_blob_report_parser.sv
verif/camera_blob_report_parser_tb.sv
